// ===== rtl/soft_pwm_motor_step_control_core_defines.svh =====
// assertion helpers for the asserting core file
`ifndef SOFT_PWM_MOTOR_STEP_CONTROL_CORE_DEFINES_SVH
`define SOFT_PWM_MOTOR_STEP_CONTROL_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off while in reset
`define SPMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while in reset
`define SPMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spmc_pkg.sv =====
`timescale 1ns / 1ps
package spmc_pkg;

    // defaults for the top level parameters
    localparam int MOTORS_DEF    = 4;
    localparam int STEP_BITS_DEF = 24;

    // fixed field widths
    localparam int TICK_W     = 16;
    localparam int SC_W       = 24;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VIS_MOTORS = 4;   // motors with edges, run lengths and packed outputs

    // request codes
    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_SET_RUN    = 2'd1;
    localparam logic [1:0] REQ_SET_TARGET = 2'd2;

    // run / drive state codes
    localparam logic [1:0] RUN_STOP = 2'd0;
    localparam logic [1:0] RUN_FWD  = 2'd1;
    localparam logic [1:0] RUN_BACK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS_3 = 3'd6;

    // per-lane command for one accepted word
    typedef struct packed {
        logic       fire;
        logic       tick;
        logic       active;
        logic       edge_hit;
        logic       step_mode;
        logic       set_run;
        logic [1:0] run_req;
        logic       set_target;
    } lane_cmd_t;

    // per-lane drive and run state
    typedef struct packed {
        logic [1:0] drive;
        logic [1:0] run;
    } lane_stat_t;

    // one result word
    typedef struct packed {
        logic [2*VIS_MOTORS-1:0] drive_states;
        logic [2*VIS_MOTORS-1:0] run_states;
        logic signed [SC_W-1:0]  step_count;
    } result_t;

endpackage

// ===== rtl/spmc_lane.sv =====
`timescale 1ns / 1ps
module spmc_lane #(
    parameter int STEP_BITS = spmc_pkg::STEP_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  spmc_pkg::lane_cmd_t                cmd,
    input  logic [spmc_pkg::TICK_W-1:0]        run_ticks,
    input  logic [spmc_pkg::TICK_W-1:0]        off_ticks,
    input  logic signed [STEP_BITS-1:0]        target_in,
    output spmc_pkg::lane_stat_t               stat_cur,
    output spmc_pkg::lane_stat_t               stat_next,
    output logic signed [STEP_BITS-1:0]        steps_next
);
    import spmc_pkg::*;

    localparam logic signed [STEP_BITS-1:0] SMAX = {1'b0, {(STEP_BITS-1){1'b1}}};
    localparam logic signed [STEP_BITS-1:0] SMIN = {1'b1, {(STEP_BITS-1){1'b0}}};

    logic [TICK_W-1:0]           cnt_reg, cnt_next;
    logic                        on_reg, on_next;
    logic [1:0]                  run_reg, run_next;
    logic [1:0]                  drive_reg, drive_next;
    logic signed [STEP_BITS-1:0] target_reg, target_next;
    logic signed [STEP_BITS-1:0] steps_reg;
    logic [TICK_W:0]             cnt_inc;
    logic [TICK_W-1:0]           limit;
    logic [STEP_BITS-1:0]        mag_steps, mag_target;
    logic                        count_down;

    always_comb
    begin
        cnt_inc    = {1'b0, cnt_reg} + {{TICK_W{1'b0}}, 1'b1};
        limit      = on_reg ? run_ticks : off_ticks;
        mag_steps  = steps_reg[STEP_BITS-1] ? $unsigned(-steps_reg) : $unsigned(steps_reg);
        mag_target = target_reg[STEP_BITS-1] ? $unsigned(-target_reg)
                                             : $unsigned(target_reg);
        count_down = cmd.step_mode && target_reg[STEP_BITS-1];

        cnt_next    = cnt_reg;
        on_next     = on_reg;
        run_next    = run_reg;
        drive_next  = drive_reg;
        target_next = target_reg;
        steps_next  = steps_reg;

        if (cmd.fire)
        begin
            if (cmd.tick && cmd.active)
            begin
                if (run_reg != RUN_STOP)
                begin
                    // phase end: drive flips, count restarts
                    if (cnt_inc >= {1'b0, limit})
                    begin
                        drive_next = on_reg ? RUN_STOP : run_reg;
                        cnt_next   = '0;
                        on_next    = !on_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[TICK_W-1:0];
                    end
                    if (cmd.step_mode && (mag_steps > mag_target))
                    begin
                        run_next = RUN_STOP;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    drive_next = RUN_STOP;
                end
                // encoder edge, saturating
                if (cmd.edge_hit)
                begin
                    if (count_down)
                    begin
                        if (steps_reg != SMIN)
                        begin
                            steps_next = steps_reg - 1'b1;
                        end
                    end
                    else if (steps_reg != SMAX)
                    begin
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            if (cmd.set_run)
            begin
                run_next = cmd.run_req;
            end
            if (cmd.set_target)
            begin
                steps_next  = '0;
                target_next = target_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            on_reg     <= 1'b1;
            run_reg    <= RUN_STOP;
            drive_reg  <= RUN_STOP;
            target_reg <= '0;
            steps_reg  <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            on_reg     <= on_next;
            run_reg    <= run_next;
            drive_reg  <= drive_next;
            target_reg <= target_next;
            steps_reg  <= steps_next;
        end
    end

    assign stat_cur.drive  = drive_reg;
    assign stat_cur.run    = run_reg;
    assign stat_next.drive = drive_next;
    assign stat_next.run   = run_next;

endmodule

// ===== rtl/spmc_merge.sv =====
`timescale 1ns / 1ps
module spmc_merge #(
    parameter int MOTORS    = spmc_pkg::MOTORS_DEF,
    parameter int STEP_BITS = spmc_pkg::STEP_BITS_DEF
) (
    input  spmc_pkg::lane_stat_t        stat [MOTORS],
    input  logic signed [STEP_BITS-1:0] steps [MOTORS],
    input  logic [1:0]                  motor_index,
    output spmc_pkg::result_t           res
);
    import spmc_pkg::*;

    localparam int SHOWN = (MOTORS < VIS_MOTORS) ? MOTORS : VIS_MOTORS;
    localparam int EXT_W = (STEP_BITS > SC_W) ? STEP_BITS : SC_W;

    logic signed [STEP_BITS-1:0] sel;
    logic signed [EXT_W-1:0]     sel_ext;

    always_comb
    begin
        res.drive_states = '0;
        res.run_states   = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            res.drive_states[2*i +: 2] = stat[i].drive;
            res.run_states[2*i +: 2]   = stat[i].run;
        end
        // addressed motor, zero when out of range
        sel = '0;
        for (int i = 0; i < MOTORS; i++)
        begin
            if (int'(motor_index) == i)
            begin
                sel = steps[i];
            end
        end
        sel_ext        = EXT_W'(sel);
        res.step_count = sel_ext[SC_W-1:0];
    end

endmodule

// ===== rtl/soft_pwm_motor_step_control_core.sv =====
// software pwm drive and encoder step counter for up to MOTORS motors
// input channel: in_valid / in_stall carry one request word (tick, set run
//   state, set step target); a word is taken when in_valid is high and
//   in_stall is low
// output channel: out_valid / out_stall carry one result word per request:
//   packed drive states, packed run states and the step count of motor_index
// result: registered in the output register, or in the skid register while it is held
// throughput: one word per cycle unless stalled; all motor lanes update in parallel in the
//   cycle of acceptance, and the merge of lane states feeds the output register
// stall: a two-deep output buffer (output register plus skid register) keeps
//   the input open while one result waits; in_stall rises only while the skid
//   register holds a word and drops the cycle after the receiver takes one
// reset: all lanes stopped, phase on, counts and steps zero, motor_count 4,
//   other registers zero, both buffers empty
// configuration: cfg_write with cfg_index / cfg_data, one register per cycle,
//   only while no word is in flight
`timescale 1ns / 1ps
`include "soft_pwm_motor_step_control_core_defines.svh"
module soft_pwm_motor_step_control_core #(
    parameter int MOTORS    = spmc_pkg::MOTORS_DEF,
    parameter int STEP_BITS = spmc_pkg::STEP_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [spmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           req_type,
    input  logic [1:0]                           motor_index,
    input  logic [1:0]                           run_state_req,
    input  logic signed [spmc_pkg::SC_W-1:0]     step_target,
    input  logic [spmc_pkg::VIS_MOTORS-1:0]      edge_mask,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2*spmc_pkg::VIS_MOTORS-1:0]    drive_states,
    output logic [2*spmc_pkg::VIS_MOTORS-1:0]    run_states,
    output logic signed [spmc_pkg::SC_W-1:0]     step_count
);
    import spmc_pkg::*;

    localparam int EXT_W = (STEP_BITS > SC_W) ? STEP_BITS : SC_W;
    localparam logic signed [STEP_BITS-1:0] SMAX = {1'b0, {(STEP_BITS-1){1'b1}}};
    localparam logic signed [STEP_BITS-1:0] SMIN = {1'b1, {(STEP_BITS-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SMAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SMIN);

    // configuration registers
    logic [CNT_W-1:0]  motor_count_reg;
    logic              step_mode_reg;
    logic [TICK_W-1:0] off_ticks_reg;
    logic [TICK_W-1:0] run_ticks_reg [VIS_MOTORS];

    // output buffer
    result_t res_next, out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    in_fire, out_free;

    // request decode
    logic                        idx_ok;
    logic                        is_tick, is_set_run, is_set_target, run_ok;
    logic signed [EXT_W-1:0]     tgt_ext;
    logic signed [STEP_BITS-1:0] target_sat;

    lane_stat_t                  stat_cur  [MOTORS];
    lane_stat_t                  stat_next [MOTORS];
    logic signed [STEP_BITS-1:0] steps_next [MOTORS];

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        idx_ok        = int'(motor_index) < MOTORS;
        is_tick       = req_type == REQ_TICK;
        is_set_run    = req_type == REQ_SET_RUN;
        is_set_target = req_type == REQ_SET_TARGET;
        // run state code three is ignored
        run_ok        = (run_state_req == RUN_STOP) || (run_state_req == RUN_FWD)
                        || (run_state_req == RUN_BACK);
        // store the target clamped to the step range
        tgt_ext = EXT_W'(step_target);
        if (tgt_ext > SAT_HI)
        begin
            target_sat = SMAX;
        end
        else if (tgt_ext < SAT_LO)
        begin
            target_sat = SMIN;
        end
        else
        begin
            target_sat = tgt_ext[STEP_BITS-1:0];
        end
    end

    // one lane per motor
    for (genvar i = 0; i < MOTORS; i++)
    begin : g_lane
        lane_cmd_t         cmd;
        logic [TICK_W-1:0] lane_run_ticks;
        logic              lane_edge;
        logic              addressed;

        if (i < VIS_MOTORS)
        begin : g_vis
            assign lane_run_ticks = run_ticks_reg[i];
            assign lane_edge      = edge_mask[i];
        end
        else
        begin : g_hidden
            // motors past the fourth run with a zero on phase and no encoder
            assign lane_run_ticks = '0;
            assign lane_edge      = 1'b0;
        end

        assign addressed = idx_ok && (int'(motor_index) == i);

        always_comb
        begin
            cmd.fire       = in_fire;
            cmd.tick       = is_tick;
            cmd.active     = motor_count_reg > CNT_W'(i);
            cmd.edge_hit   = lane_edge && (motor_count_reg > CNT_W'(i));
            cmd.step_mode  = step_mode_reg;
            cmd.set_run    = is_set_run && addressed && run_ok;
            cmd.run_req    = run_state_req;
            cmd.set_target = is_set_target && addressed;
        end

        spmc_lane #(
            .STEP_BITS (STEP_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .run_ticks  (lane_run_ticks),
            .off_ticks  (off_ticks_reg),
            .target_in  (target_sat),
            .stat_cur   (stat_cur[i]),
            .stat_next  (stat_next[i]),
            .steps_next (steps_next[i])
        );
    end

    // merge lane states into the result word
    spmc_merge #(
        .MOTORS    (MOTORS),
        .STEP_BITS (STEP_BITS)
    ) u_merge (
        .stat        (stat_next),
        .steps       (steps_next),
        .motor_index (motor_index),
        .res         (res_next)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_count_reg <= CNT_W'(VIS_MOTORS);
            step_mode_reg   <= 1'b0;
            off_ticks_reg   <= '0;
            for (int i = 0; i < VIS_MOTORS; i++)
            begin
                run_ticks_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MOTOR_COUNT: motor_count_reg  <= cfg_data[CNT_W-1:0];
                CFG_STEP_MODE:   step_mode_reg    <= cfg_data[0];
                CFG_OFF_TICKS:   off_ticks_reg    <= cfg_data[TICK_W-1:0];
                CFG_RUN_TICKS_0: run_ticks_reg[0] <= cfg_data[TICK_W-1:0];
                CFG_RUN_TICKS_1: run_ticks_reg[1] <= cfg_data[TICK_W-1:0];
                CFG_RUN_TICKS_2: run_ticks_reg[2] <= cfg_data[TICK_W-1:0];
                CFG_RUN_TICKS_3: run_ticks_reg[3] <= cfg_data[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_states = out_reg.drive_states;
    assign run_states   = out_reg.run_states;
    assign step_count   = out_reg.step_count;

    // skid word only ever sits behind a held output word
    `SPMC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid without output")
    // a taken output empties the skid stage in the next cycle
    `SPMC_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, !skid_valid_reg, "skid stuck")
    // a stopped active motor 0 shows a stop drive after a tick
    `SPMC_ASSERT_NEXT(a_stop_drive,
        in_fire && is_tick && (motor_count_reg != '0) && (stat_cur[0].run == RUN_STOP),
        stat_cur[0].drive == RUN_STOP, "stopped motor still driven")

endmodule

// ===== test/tb_soft_pwm_motor_step_control_core.sv =====
`timescale 1ns / 1ps
module tb_soft_pwm_motor_step_control_core;
    import spmc_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam logic [1:0] RUN_BAD = 2'd3;

    localparam int NUM_MOTORS = MOTORS_DEF;
    localparam longint STEP_MAX = (longint'(1) << (STEP_BITS_DEF - 1)) - 1;
    localparam longint STEP_MIN = -STEP_MAX - 1;

    // random part: phases of words, each with its own register setting and idling
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS = 100;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one line of stimulus: either a register write or a request word
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [1:0]            req;
        logic [1:0]            idx;
        logic [1:0]            rs;
        logic signed [SC_W-1:0] tgt;
        logic [VIS_MOTORS-1:0] edges;
        bit                    typed;
        logic [7:0]            want_drive;
        logic [7:0]            want_run;
        logic signed [SC_W-1:0] want_sc;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic [1:0] motor_index;
    logic [1:0] run_state_req;
    logic signed [SC_W-1:0] step_target;
    logic [VIS_MOTORS-1:0] edge_mask;
    logic out_valid;
    logic out_stall;
    logic [2*VIS_MOTORS-1:0] drive_states;
    logic [2*VIS_MOTORS-1:0] run_states;
    logic signed [SC_W-1:0] step_count;

    // idling knobs for the sender and the receiver
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    // motor model: per-motor pwm and step state plus the register copies
    int unsigned tick_cnt [NUM_MOTORS];
    bit phase_on [NUM_MOTORS];
    logic [1:0] run_st [NUM_MOTORS];
    logic [1:0] drive_st [NUM_MOTORS];
    longint target_st [NUM_MOTORS];
    longint steps_st [NUM_MOTORS];
    int unsigned motors_used;
    bit step_mode_on;
    int unsigned off_len;
    int unsigned run_len [VIS_MOTORS];

    // results still owed by the block, oldest first
    result_t pending_results[$];
    int error_count = 0;

    soft_pwm_motor_step_control_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .motor_index  (motor_index),
        .run_state_req(run_state_req),
        .step_target  (step_target),
        .edge_mask    (edge_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_states (drive_states),
        .run_states   (run_states),
        .step_count   (step_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic reset_motor_model();
        motors_used = 4;
        step_mode_on = 1'b0;
        off_len = 0;
        for (int i = 0; i < VIS_MOTORS; i++)
        begin
            run_len[i] = 0;
        end
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            tick_cnt[i] = 0;
            phase_on[i] = 1'b1;
            run_st[i] = RUN_STOP;
            drive_st[i] = RUN_STOP;
            target_st[i] = 0;
            steps_st[i] = 0;
        end
    endtask

    // apply one request word to the motor model and return the result word it gives
    task automatic advance_motors(input stim_row_t w, output result_t res);
        int active;
        int unsigned limit;
        longint dir;
        active = (motors_used > NUM_MOTORS) ? NUM_MOTORS : int'(motors_used);
        case (w.req)
            REQ_TICK:
            begin
                // pwm first, for every active motor
                for (int i = 0; i < active; i++)
                begin
                    if (run_st[i] != RUN_STOP)
                    begin
                        limit = phase_on[i] ? run_len[i] : off_len;
                        tick_cnt[i]++;
                        if (tick_cnt[i] >= limit)
                        begin
                            // end of on phase drops the drive, end of off phase restores it
                            drive_st[i] = phase_on[i] ? RUN_STOP : run_st[i];
                            tick_cnt[i] = 0;
                            phase_on[i] = !phase_on[i];
                        end
                        if (step_mode_on && mag_of(steps_st[i]) > mag_of(target_st[i]))
                        begin
                            run_st[i] = RUN_STOP;
                        end
                    end
                    else
                    begin
                        // stopped motor: count cleared, phase kept
                        tick_cnt[i] = 0;
                        drive_st[i] = RUN_STOP;
                    end
                end
                // then the encoder edges, after the stop decision
                for (int i = 0; i < active; i++)
                begin
                    if (w.edges[i])
                    begin
                        dir = (target_st[i] >= 0 || !step_mode_on) ? 1 : -1;
                        steps_st[i] = steps_st[i] + dir;
                        if (steps_st[i] > STEP_MAX)
                        begin
                            steps_st[i] = STEP_MAX;
                        end
                        if (steps_st[i] < STEP_MIN)
                        begin
                            steps_st[i] = STEP_MIN;
                        end
                    end
                end
            end
            REQ_SET_RUN:
            begin
                // code three is not a run state and is dropped
                if (w.rs != RUN_BAD)
                begin
                    run_st[w.idx] = w.rs;
                end
            end
            REQ_SET_TARGET:
            begin
                steps_st[w.idx] = 0;
                target_st[w.idx] = longint'(w.tgt);
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < VIS_MOTORS; i++)
        begin
            res.drive_states[2*i +: 2] = drive_st[i];
            res.run_states[2*i +: 2] = run_st[i];
        end
        res.step_count = steps_st[w.idx][SC_W-1:0];
    endtask

    function automatic stim_row_t word_row(input logic [1:0] req, input logic [1:0] idx,
                                           input logic [1:0] rs, input logic signed [SC_W-1:0] tgt,
                                           input logic [VIS_MOTORS-1:0] edges);
        stim_row_t r;
        r = '{default: '0};
        r.req = req;
        r.idx = idx;
        r.rs = rs;
        r.tgt = tgt;
        r.edges = edges;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [1:0] req, input logic [1:0] idx,
                                            input logic [1:0] rs,
                                            input logic signed [SC_W-1:0] tgt,
                                            input logic [VIS_MOTORS-1:0] edges,
                                            input logic [7:0] drv, input logic [7:0] run,
                                            input logic signed [SC_W-1:0] sc);
        stim_row_t r;
        r = word_row(req, idx, rs, tgt, edges);
        r.typed = 1'b1;
        r.want_drive = drv;
        r.want_run = run;
        r.want_sc = sc;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // offer one word, hold it while stalled, log its expected result on acceptance
    task automatic send_word(input stim_row_t w);
        result_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = w.req;
        motor_index = w.idx;
        run_state_req = w.rs;
        step_target = w.tgt;
        edge_mask = w.edges;
        do
            @(posedge clk);
        while (in_stall);
        advance_motors(w, predicted);
        if (w.typed)
        begin
            predicted.drive_states = w.want_drive;
            predicted.run_states = w.want_run;
            predicted.step_count = w.want_sc;
        end
        pending_results = {pending_results, predicted};
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic settle_idle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_MOTOR_COUNT: motors_used = val[CNT_W-1:0];
            CFG_STEP_MODE:   step_mode_on = val[0];
            CFG_OFF_TICKS:   off_len = val;
            CFG_RUN_TICKS_0: run_len[0] = val;
            CFG_RUN_TICKS_1: run_len[1] = val;
            CFG_RUN_TICKS_2: run_len[2] = val;
            CFG_RUN_TICKS_3: run_len[3] = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic set_idling(input idle_mode_t mode);
        send_gap_pct = (mode == IDLE_SENDER) ? 60 : (mode == IDLE_BOTH) ? 12 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 60 : (mode == IDLE_BOTH) ? 12 : 0;
    endtask

    // mostly ticks and run commands so motors keep cycling, small targets so
    // step mode stops them, now and then a full-range target or a bad code
    function automatic stim_row_t random_word();
        int roll;
        int pick;
        logic [1:0] req;
        logic [1:0] rs;
        logic signed [SC_W-1:0] tgt;
        roll = $urandom_range(99);
        if (roll < 62)
        begin
            req = REQ_TICK;
        end
        else if (roll < 82)
        begin
            req = REQ_SET_RUN;
        end
        else if (roll < 94)
        begin
            req = REQ_SET_TARGET;
        end
        else
        begin
            req = REQ_NOP;
        end
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            rs = RUN_BAD;
        end
        else if (pick < 3)
        begin
            rs = RUN_STOP;
        end
        else if (pick < 7)
        begin
            rs = RUN_FWD;
        end
        else
        begin
            rs = RUN_BACK;
        end
        if ($urandom_range(7) == 0)
        begin
            tgt = SC_W'($urandom);
        end
        else
        begin
            tgt = SC_W'(int'($urandom_range(16)) - 8);
        end
        return word_row(req, 2'($urandom), rs, tgt, VIS_MOTORS'($urandom));
    endfunction

    // receiver: random stall per cycle, or a counted hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // result checker: every word taken from the block must match the oldest expectation
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing expected", step_count, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (drive_states !== want.drive_states)
                begin
                    report_mismatch("drive_states", drive_states, want.drive_states);
                end
                if (run_states !== want.run_states)
                begin
                    report_mismatch("run_states", run_states, want.run_states);
                end
                if (step_count !== want.step_count)
                begin
                    report_mismatch("step_count", step_count, want.step_count);
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t dir_rows[$];
        logic [CNT_W-1:0] count_val;
        logic [CFG_DATA_W-1:0] mode_val;
        logic [CFG_DATA_W-1:0] off_val;
        logic [CFG_DATA_W-1:0] run_val [VIS_MOTORS];

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        motor_index = '0;
        run_state_req = RUN_STOP;
        step_target = '0;
        edge_mask = '0;
        reset_motor_model();

        // directed words: reset values, extreme targets, bad codes, zero phase
        // lengths, stopped motors, step mode stop on a negative target, motor
        // count of zero and above the motor total
        dir_rows = '{
            // after reset everything reads zero
            typed_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'h0, 8'h00, 8'h00, 24'sd0),
            // new targets clear the step count
            typed_row(REQ_SET_TARGET, 2'd1, RUN_STOP, 24'sh7FFFFF, 4'h0, 8'h00, 8'h00, 24'sd0),
            typed_row(REQ_SET_TARGET, 2'd2, RUN_STOP, 24'sh800000, 4'h0, 8'h00, 8'h00, 24'sd0),
            // request code three does nothing but still answers
            typed_row(REQ_NOP, 2'd3, RUN_STOP, 24'sd0, 4'h0, 8'h00, 8'h00, 24'sd0),
            // run code three is dropped
            typed_row(REQ_SET_RUN, 2'd0, RUN_BAD, 24'sd0, 4'h0, 8'h00, 8'h00, 24'sd0),
            typed_row(REQ_SET_RUN, 2'd0, RUN_FWD, 24'sd0, 4'h0, 8'h00, 8'h01, 24'sd0),
            typed_row(REQ_SET_RUN, 2'd3, RUN_BACK, 24'sd0, 4'h0, 8'h00, 8'h81, 24'sd0),
            // zero on length ends the on phase at once, every edge counts up
            typed_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'hF, 8'h00, 8'h81, 24'sd1),
            // zero off length brings the drive back on the next tick
            typed_row(REQ_TICK, 2'd3, RUN_STOP, 24'sd0, 4'h0, 8'h81, 8'h81, 24'sd1),
            word_row(REQ_SET_RUN, 2'd1, RUN_FWD, 24'sd0, 4'h0),
            word_row(REQ_TICK, 2'd1, RUN_STOP, 24'sd0, 4'h5),
            // stopped motor forces its drive off but keeps counting edges
            word_row(REQ_SET_RUN, 2'd0, RUN_STOP, 24'sd0, 4'h0),
            word_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'hA),
            reg_row(CFG_STEP_MODE, 16'd1),
            reg_row(CFG_RUN_TICKS_0, 16'd2),
            reg_row(CFG_OFF_TICKS, 16'd1),
            // negative target in step mode: counts down, stops past the target
            word_row(REQ_SET_TARGET, 2'd0, RUN_STOP, -24'sd2, 4'h0),
            word_row(REQ_SET_RUN, 2'd0, RUN_BACK, 24'sd0, 4'h0),
            word_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'h1),
            word_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'h1),
            word_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'h1),
            word_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'h1),
            word_row(REQ_TICK, 2'd0, RUN_STOP, 24'sd0, 4'h0),
            // no motor active
            reg_row(CFG_MOTOR_COUNT, 16'd0),
            word_row(REQ_TICK, 2'd2, RUN_STOP, 24'sd0, 4'hF),
            // count above the motor total is clamped
            reg_row(CFG_MOTOR_COUNT, 16'd7),
            word_row(REQ_TICK, 2'd3, RUN_STOP, 24'sd0, 4'hF)
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_reg)
            begin
                settle_idle();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end
            else
            begin
                send_word(dir_rows[r]);
            end
        end

        // random phases, each with a fresh register setting and its own idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // lowest lengths, time mode
                    count_val = 3'd4;
                    mode_val = 16'd0;
                    off_val = 16'd0;
                    foreach (run_val[m])
                    begin
                        run_val[m] = 16'd0;
                    end
                end
                1:
                begin
                    // longest lengths, step mode, clamped count
                    count_val = 3'd7;
                    mode_val = 16'd1;
                    off_val = 16'hFFFF;
                    foreach (run_val[m])
                    begin
                        run_val[m] = 16'hFFFF;
                    end
                end
                2:
                begin
                    count_val = 3'd0;
                    mode_val = 16'($urandom_range(1));
                    off_val = 16'd1;
                    foreach (run_val[m])
                    begin
                        run_val[m] = 16'd1;
                    end
                end
                default:
                begin
                    // short phases so the pwm flips often
                    count_val = 3'($urandom_range(1, 4));
                    mode_val = 16'($urandom_range(1));
                    off_val = 16'($urandom_range(3));
                    foreach (run_val[m])
                    begin
                        run_val[m] = 16'($urandom_range(5));
                    end
                end
            endcase
            settle_idle();
            write_reg(CFG_MOTOR_COUNT, CFG_DATA_W'(count_val));
            write_reg(CFG_STEP_MODE, mode_val);
            write_reg(CFG_OFF_TICKS, off_val);
            write_reg(CFG_RUN_TICKS_0, run_val[0]);
            write_reg(CFG_RUN_TICKS_1, run_val[1]);
            write_reg(CFG_RUN_TICKS_2, run_val[2]);
            write_reg(CFG_RUN_TICKS_3, run_val[3]);
            set_idling(idle_mode_t'(p % 4));

            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // long receiver hold-off while words keep coming, fills the skid buffer
                if (p == 5 && k == 30)
                begin
                    hold_left = HOLD_CYCLES;
                end
                // sender pause until the block has handed back everything
                if (p == 6 && k == 50)
                begin
                    settle_idle();
                end
                send_word(random_word());
            end
        end

        settle_idle();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("result words never delivered", pending_results.size(), 0);
        end
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
